// ===== sv/bipartite_ring_space_manager_top_macros.svh =====
// assertion macros for the bipartite ring space manager
`ifndef BIPARTITE_RING_SPACE_MANAGER_TOP_MACROS_SVH
`define BIPARTITE_RING_SPACE_MANAGER_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BRSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define BRSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/brsm_pkg.sv =====
// types and constants shared by the ring space manager files
package brsm_pkg;

  localparam int unsigned OffW   = 17;
  localparam int unsigned StartW = 16;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [OffW-1:0] MaxBytes = 17'd65536;

  // register index as seen on paddr[2]
  localparam logic RegBufferBytes = 1'b0;

  typedef enum logic [1:0] {
    ReqReserve = 2'd0,
    ReqCommit  = 2'd1,
    ReqRead    = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [OffW-1:0] amount;
    logic [OffW-1:0] commit_end;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [StartW-1:0] region_start;
    logic [OffW-1:0]   read_length;
    logic [OffW-1:0]   fill_level;
  } rsp_t;

  typedef struct packed {
    logic            wr;
    logic [OffW-1:0] wr_bytes;
    logic [OffW-1:0] bytes;
  } cfg_t;

endpackage

// ===== sv/brsm_req_if.sv =====
// request channel: valid/ready plus the request fields
interface brsm_req_if;
  import brsm_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      req_type;
  logic [OffW-1:0] amount;
  logic [OffW-1:0] commit_end;

  modport source (output valid, req_type, amount, commit_end, input ready);
  modport sink   (input valid, req_type, amount, commit_end, output ready);
endinterface

// ===== sv/brsm_rsp_if.sv =====
// result channel: valid/ready plus the result fields
interface brsm_rsp_if;
  import brsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              granted;
  logic [StartW-1:0] region_start;
  logic [OffW-1:0]   read_length;
  logic [OffW-1:0]   fill_level;

  modport source (output valid, granted, region_start, read_length, fill_level, input ready);
  modport sink   (input valid, granted, region_start, read_length, fill_level, output ready);
endinterface

// ===== sv/brsm_regs.sv =====
// apb configuration register holding the buffer length
module brsm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brsm_pkg::AddrW-1:0]    paddr,
  input  logic [brsm_pkg::DataW-1:0]    pwdata,
  output logic [brsm_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output brsm_pkg::cfg_t                cfg_o
);
  import brsm_pkg::*;

  logic [OffW-1:0] bytes_q, bytes_d;
  logic [OffW-1:0] wr_val;
  logic            wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == RegBufferBytes);

  // saturate the written length into 1..MaxBytes
  always_comb begin
    wr_val = pwdata[OffW-1:0];
    if (wr_val == '0) begin
      wr_val = {{(OffW-1){1'b0}}, 1'b1};
    end else if (wr_val > MaxBytes) begin
      wr_val = MaxBytes;
    end
    bytes_d = wr_en ? wr_val : bytes_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= MaxBytes;
    end else begin
      bytes_q <= bytes_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBufferBytes)
                ? {{(DataW-OffW){1'b0}}, bytes_q} : '0;

  assign cfg_o.wr       = wr_en;
  assign cfg_o.wr_bytes = wr_val;
  assign cfg_o.bytes    = bytes_q;
endmodule

// ===== sv/brsm_engine.sv =====
// offset state and the single-pass reserve/commit/read step
module brsm_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  brsm_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  brsm_pkg::req_t req_i,
  output brsm_pkg::rsp_t rsp_o
);
  import brsm_pkg::*;

  logic [OffW-1:0] ro_q, ro_d;
  logic [OffW-1:0] wo_q, wo_d;
  logic [OffW-1:0] hm_q, hm_d;
  logic [OffW-1:0] avail;
  logic [OffW-1:0] len;
  logic [OffW-1:0] start;
  logic            granted;

  always_comb begin
    ro_d    = ro_q;
    wo_d    = wo_q;
    hm_d    = hm_q;
    granted = 1'b0;
    start   = '0;
    len     = '0;
    avail   = '0;
    if (cfg_i.wr) begin
      ro_d = '0;
      wo_d = '0;
      hm_d = cfg_i.wr_bytes;
    end else if (step_i) begin
      case (req_e'(req_i.req_type))
        ReqReserve: begin
          if (ro_q <= wo_q) begin
            if (hm_q >= wo_q && (hm_q - wo_q) >= req_i.amount) begin
              granted = 1'b1;
              start   = wo_q;
            end else if (ro_q > req_i.amount) begin
              granted = 1'b1;
            end
          end else if ((ro_q - wo_q) > req_i.amount) begin
            granted = 1'b1;
            start   = wo_q;
          end
        end
        ReqCommit: begin
          if (req_i.commit_end <= cfg_i.bytes) begin
            // a backward commit means the write wrapped: remember the old end
            if (req_i.commit_end < wo_q) begin
              hm_d = wo_q;
            end
            wo_d    = req_i.commit_end;
            granted = 1'b1;
          end
        end
        ReqRead: begin
          if (wo_q >= ro_q) begin
            avail = wo_q - ro_q;
          end else if (hm_q > ro_q) begin
            avail = hm_q - ro_q;
          end
          len  = (avail < req_i.amount) ? avail : req_i.amount;
          ro_d = ro_q + len;
          if (len != '0) begin
            granted = 1'b1;
            start   = ro_q;
            if (wo_q >= ro_q) begin
              // drained completely: restart both offsets at zero
              if (ro_d == wo_q) begin
                ro_d = '0;
                wo_d = '0;
              end
            end else if (ro_d == hm_q) begin
              ro_d = '0;
              hm_d = cfg_i.bytes;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_q <= '0;
      wo_q <= '0;
      hm_q <= MaxBytes;
    end else begin
      ro_q <= ro_d;
      wo_q <= wo_d;
      hm_q <= hm_d;
    end
  end

  always_comb begin
    rsp_o.granted      = granted;
    rsp_o.region_start = start[StartW-1:0];
    rsp_o.read_length  = len;
    if (wo_d >= ro_d) begin
      rsp_o.fill_level = wo_d - ro_d;
    end else if (hm_d >= ro_d) begin
      rsp_o.fill_level = hm_d - ro_d + wo_d;
    end else begin
      rsp_o.fill_level = wo_d;
    end
  end
endmodule

// ===== sv/bipartite_ring_space_manager_top.sv =====
// top level of the bipartite ring space manager
// a request passes through the input reg, then the result reg, before its result is valid
// one request per cycle unless a result stalls; offsets and result reg load in the same cycle
// a stalled result holds the result reg, and the input reg takes one more request
// reset clears both offsets and sets buffer length and watermark to 65536
`include "bipartite_ring_space_manager_top_macros.svh"
module bipartite_ring_space_manager_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  brsm_req_if.sink                   req_i,
  brsm_rsp_if.source                 rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [brsm_pkg::AddrW-1:0] paddr,
  input  logic [brsm_pkg::DataW-1:0] pwdata,
  output logic [brsm_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import brsm_pkg::*;

  cfg_t cfg;
  req_t in_q;
  rsp_t step_rsp;
  rsp_t out_q;
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  brsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  brsm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .req_i  (in_q),
    .rsp_o  (step_rsp)
  );

  // the held request moves on when the result slot is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type   <= req_i.req_type;
      in_q.amount     <= req_i.amount;
      in_q.commit_end <= req_i.commit_end;
    end
    if (advance) begin
      out_q <= step_rsp;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted      = out_q.granted;
  assign rsp_o.region_start = out_q.region_start;
  assign rsp_o.read_length  = out_q.read_length;
  assign rsp_o.fill_level   = out_q.fill_level;

  `BRSM_ASSERT_IMPL(a_full_blocks_req, in_valid_q && out_valid_q && !rsp_o.ready, !req_i.ready, "request taken while both stages are full")
  `BRSM_ASSERT_IMPL(a_fill_in_range, out_valid_q, out_q.fill_level <= cfg.bytes, "fill level above buffer length")
  `BRSM_ASSERT_IMPL(a_denied_is_clean, out_valid_q && !out_q.granted, out_q.region_start == '0 && out_q.read_length == '0, "denied result carries a region")
  `BRSM_ASSERT(a_len_needs_grant, !(out_valid_q && out_q.read_length != '0 && !out_q.granted), "read length without grant")
endmodule
